// File: design/step_sequenced_am_oscillator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the AM oscillator
// Concurrent assertion wrappers that compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef STEP_SEQUENCED_AM_OSCILLATOR_MACROS_SVH
`define STEP_SEQUENCED_AM_OSCILLATOR_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define SAO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sao assertion failed");
// A consequent that must hold in the cycle after the antecedent.
`define SAO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sao assertion failed");
`else
`define SAO_ASSERT(lbl, clk, rst_n, prop)
`define SAO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/sao_pkg.sv
// ----------------------------------------------------------------------------
// AM oscillator package
// Request codes, field widths, the quarter-wave sine table and shared types.
// ----------------------------------------------------------------------------
package sao_pkg;

  localparam int REQ_W      = 2;
  localparam int ENTRY_W    = 4;
  localparam int MULT_W     = 5;
  localparam int HEIGHT_W   = 10;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_OUT_W = 4;

  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STEP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd2;

  // Carrier is the multiple times 60 Hz; every multiple code has an increment.
  localparam int CAR_HZ = 60;
  localparam int MULT_N = 1 << MULT_W;

  // Modulator Hz is (640 - height) / 20, done as a multiply by 3277 / 2^16,
  // which is exact for every difference from 0 to 640.
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 10'd640;
  localparam int                  MOD_DIV_W  = HEIGHT_W + 12;
  localparam logic [11:0]         MOD_RECIP  = 12'd3277;
  localparam int                  MOD_HZ_W   = 6;
  localparam int                  MOD_HZ_N   = 33;

  localparam int SINE_BITS = 10;
  localparam int QTR       = 1 << (SINE_BITS - 2);
  localparam int QIDX_W    = SINE_BITS - 1;

  typedef logic [SAMPLE_W-2:0] sine_mag_t;
  typedef sine_mag_t sine_qtr_t [0:QTR];

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] car_s;
    logic signed [SAMPLE_W-1:0] mdl_s;
    logic [STEP_OUT_W-1:0]      step;
  } sao_pair_t;

  // Quarter-wave magnitudes from an odd Q30 series up to x^11, evaluated
  // at elaboration only.
  function automatic sine_qtr_t build_sine_qtr();
    sine_qtr_t   tbl;
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    one = 64'd1 << 30;
    for (int r = 0; r <= QTR; r++) begin
      x  = (64'(r) * 64'd6746518852 + (64'd1 << (SINE_BITS - 1))) >> SINE_BITS;
      x2 = (x * x) >> 30;
      t  = one;
      t  = one - ((x2 * t) >> 30) / 64'd110;
      t  = one - ((x2 * t) >> 30) / 64'd72;
      t  = one - ((x2 * t) >> 30) / 64'd42;
      t  = one - ((x2 * t) >> 30) / 64'd20;
      t  = one - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (one >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tbl[r] = v[SAMPLE_W-2:0];
    end
    return tbl;
  endfunction

  localparam sine_qtr_t SINE_QTR = build_sine_qtr();

  // Full-wave lookup by quadrant folding of the quarter table.
  function automatic logic signed [SAMPLE_W-1:0] sine_lookup(
    input logic [SINE_BITS-1:0] idx
  );
    logic [1:0]          quad;
    logic [QIDX_W-1:0]   rr;
    sine_mag_t           mag;
    logic [SAMPLE_W-1:0] pos;
    quad = idx[SINE_BITS-1 -: 2];
    rr   = {1'b0, idx[SINE_BITS-3:0]};
    if (quad[0]) begin
      rr = QIDX_W'(QTR) - rr;
    end
    mag = SINE_QTR[rr];
    pos = {1'b0, mag};
    return quad[1] ? $signed(-pos) : $signed(pos);
  endfunction

endpackage

// File: design/sao_front.sv
// ----------------------------------------------------------------------------
// AM oscillator front end
// Input register, step tables, phase accumulators and the two sine lookups.
// ----------------------------------------------------------------------------
`include "step_sequenced_am_oscillator_macros.svh"

module sao_front #(
  parameter int STEPS       = 16,
  parameter int SAMPLE_RATE = 44100,
  parameter int PHASE_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sao_pkg::REQ_W-1:0]           in_req_type,
  input  logic [sao_pkg::ENTRY_W-1:0]         in_entry_index,
  input  logic [sao_pkg::MULT_W-1:0]          in_carrier_multiple,
  input  logic [sao_pkg::HEIGHT_W-1:0]        in_mod_height,
  output logic                                smp_valid,
  input  logic                                smp_ready,
  output sao_pkg::sao_pair_t                  smp
);

  localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;
  // Only entries an entry index can reach need storage; the rest stay at reset.
  localparam int WR = (STEPS < (1 << sao_pkg::ENTRY_W)) ? STEPS : (1 << sao_pkg::ENTRY_W);
  localparam int IW = (WR > 1) ? $clog2(WR) : 1;
  localparam logic [63:0] CAR_RST_HZ = 64'(sao_pkg::CAR_HZ);
  localparam logic [63:0] CAR_RST_INC =
    ((CAR_RST_HZ << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
  localparam logic [PHASE_BITS-1:0] CAR_INC_RST = CAR_RST_INC[PHASE_BITS-1:0];

  logic                          s1_valid_r, s1_valid_nxt;
  logic [sao_pkg::REQ_W-1:0]     s1_type_r;
  logic [sao_pkg::ENTRY_W-1:0]   s1_entry_r;
  logic [sao_pkg::MULT_W-1:0]    s1_mult_r;
  logic [sao_pkg::HEIGHT_W-1:0]  s1_height_r;

  logic                          s2_valid_r, s2_valid_nxt;
  sao_pkg::sao_pair_t            s2_pair_r;

  logic [SW-1:0]                 step_r, step_nxt;
  logic [PHASE_BITS-1:0]         car_phase_r, mod_phase_r;
  logic [PHASE_BITS-1:0]         car_inc_r [0:WR-1];
  logic [PHASE_BITS-1:0]         mod_inc_r [0:WR-1];

  logic [PHASE_BITS-1:0]         car_inc_tbl [0:sao_pkg::MULT_N-1];
  logic [PHASE_BITS-1:0]         mod_inc_tbl [0:sao_pkg::MOD_HZ_N-1];

  logic                          s2_free, proc, proc_smp, proc_step, proc_wr;
  logic [sao_pkg::HEIGHT_W-1:0]  h_clamp, h_diff;
  logic [sao_pkg::MOD_DIV_W-1:0] fm_prod;
  logic [sao_pkg::MOD_HZ_W-1:0]  fm_hz;
  logic [PHASE_BITS-1:0]         wr_car_inc, wr_mod_inc, use_car_inc, use_mod_inc;
  logic                          step_stored;

  for (genvar g = 0; g < sao_pkg::MULT_N; g++) begin : g_car_inc
    localparam logic [63:0] HZ  = 64'(g) * 64'(sao_pkg::CAR_HZ);
    localparam logic [63:0] INC = ((HZ << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) /
                                  64'(SAMPLE_RATE);
    assign car_inc_tbl[g] = INC[PHASE_BITS-1:0];
  end

  for (genvar g = 0; g < sao_pkg::MOD_HZ_N; g++) begin : g_mod_inc
    localparam logic [63:0] HZ  = 64'(g);
    localparam logic [63:0] INC = ((HZ << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) /
                                  64'(SAMPLE_RATE);
    assign mod_inc_tbl[g] = INC[PHASE_BITS-1:0];
  end

  // A sample item needs a free slot in the sine register; other items retire here.
  assign s2_free   = !s2_valid_r || smp_ready;
  assign proc      = s1_valid_r && ((s1_type_r != sao_pkg::REQ_SAMPLE) || s2_free);
  assign proc_smp  = proc && (s1_type_r == sao_pkg::REQ_SAMPLE);
  assign proc_step = proc && (s1_type_r == sao_pkg::REQ_STEP);
  assign proc_wr   = proc && (s1_type_r == sao_pkg::REQ_WRITE) && (32'(s1_entry_r) < STEPS);
  assign in_ready  = !s1_valid_r || proc;

  // Increments are worked out when an entry is written, so a sample only adds.
  always_comb begin
    h_clamp    = (s1_height_r > sao_pkg::MAX_HEIGHT) ? sao_pkg::MAX_HEIGHT : s1_height_r;
    h_diff     = sao_pkg::MAX_HEIGHT - h_clamp;
    fm_prod    = sao_pkg::MOD_DIV_W'(h_diff) * sao_pkg::MOD_DIV_W'(sao_pkg::MOD_RECIP);
    fm_hz      = fm_prod[sao_pkg::MOD_DIV_W-1 -: sao_pkg::MOD_HZ_W];
    wr_car_inc = car_inc_tbl[s1_mult_r];
    wr_mod_inc = mod_inc_tbl[fm_hz];
  end

  always_comb begin
    step_stored = 32'(step_r) < WR;
    use_car_inc = step_stored ? car_inc_r[step_r[IW-1:0]] : CAR_INC_RST;
    use_mod_inc = step_stored ? mod_inc_r[step_r[IW-1:0]] : '0;
  end

  always_comb begin
    step_nxt = step_r;
    if (proc_step) begin
      step_nxt = (step_r == SW'(STEPS - 1)) ? '0 : step_r + 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    s2_valid_nxt = s2_valid_r;
    if (proc_smp) begin
      s2_valid_nxt = 1'b1;
    end else if (smp_ready) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      step_r      <= '0;
      car_phase_r <= '0;
      mod_phase_r <= '0;
      for (int i = 0; i < WR; i++) begin
        car_inc_r[i] <= CAR_INC_RST;
        mod_inc_r[i] <= '0;
      end
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      step_r     <= step_nxt;
      if (proc_smp) begin
        car_phase_r <= car_phase_r + use_car_inc;
        mod_phase_r <= mod_phase_r + use_mod_inc;
      end
      if (proc_wr) begin
        car_inc_r[s1_entry_r[IW-1:0]] <= wr_car_inc;
        mod_inc_r[s1_entry_r[IW-1:0]] <= wr_mod_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_type_r   <= in_req_type;
      s1_entry_r  <= in_entry_index;
      s1_mult_r   <= in_carrier_multiple;
      s1_height_r <= in_mod_height;
    end
    if (proc_smp) begin
      s2_pair_r.car_s <= sao_pkg::sine_lookup(car_phase_r[PHASE_BITS-1 -: sao_pkg::SINE_BITS]);
      s2_pair_r.mdl_s <= sao_pkg::sine_lookup(mod_phase_r[PHASE_BITS-1 -: sao_pkg::SINE_BITS]);
      s2_pair_r.step  <= sao_pkg::STEP_OUT_W'(step_r);
    end
  end

  assign smp_valid = s2_valid_r;
  assign smp       = s2_pair_r;

  `SAO_ASSERT(a_step_range, clk, rst_n, 32'(step_r) < STEPS)
  `SAO_ASSERT_NEXT(a_phase_hold, clk, rst_n, !proc_smp, $stable(car_phase_r) && $stable(mod_phase_r))
  `SAO_ASSERT_NEXT(a_s2_hold, clk, rst_n, s2_valid_r && !smp_ready, s2_valid_r && $stable(s2_pair_r))

endmodule

// File: design/sao_mix.sv
// ----------------------------------------------------------------------------
// AM oscillator mixer
// Scales the carrier sine by the modulator gain and holds the result item.
// ----------------------------------------------------------------------------
`include "step_sequenced_am_oscillator_macros.svh"

module sao_mix (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  smp_valid,
  output logic                                  smp_ready,
  input  sao_pkg::sao_pair_t                    smp,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sao_pkg::SAMPLE_W-1:0]   out_sample,
  output logic [sao_pkg::STEP_OUT_W-1:0]        out_current_step
);

  localparam int MW = sao_pkg::SAMPLE_W - 1;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [sao_pkg::SAMPLE_W-1:0] out_sample_r;
  logic [sao_pkg::STEP_OUT_W-1:0]      out_step_r;

  logic [sao_pkg::SAMPLE_W-1:0]        car_abs;
  logic [MW-1:0]                       gain;
  logic [2*MW-1:0]                     mag;
  logic [2*MW:0]                       rnd;
  logic [sao_pkg::SAMPLE_W-1:0]        res;
  logic signed [sao_pkg::SAMPLE_W-1:0] sample_nxt;

  // Gain is (modulator + 32768) >> 1: flip the sign bit and drop the low bit.
  always_comb begin
    car_abs    = smp.car_s[sao_pkg::SAMPLE_W-1] ? -smp.car_s : smp.car_s;
    gain       = {~smp.mdl_s[sao_pkg::SAMPLE_W-1], smp.mdl_s[sao_pkg::SAMPLE_W-2:1]};
    mag        = (2*MW)'(car_abs[MW-1:0]) * (2*MW)'(gain);
    rnd        = {1'b0, mag} + (2*MW+1)'(1 << (MW - 1));
    res        = rnd[2*MW -: sao_pkg::SAMPLE_W];
    sample_nxt = smp.car_s[sao_pkg::SAMPLE_W-1] ? $signed(-res) : $signed(res);
  end

  assign smp_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (smp_ready) begin
      out_valid_nxt = smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_valid && smp_ready) begin
      out_sample_r <= sample_nxt;
      out_step_r   <= smp.step;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_current_step = out_step_r;

  `SAO_ASSERT(a_no_full_neg, clk, rst_n, !out_valid_r || (out_sample_r != 16'sh8000))

endmodule

// File: design/step_sequenced_am_oscillator.sv
// ----------------------------------------------------------------------------
// Step-sequenced AM oscillator
// Carrier sine scaled by a raised modulator sine, with per-step frequencies.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the in_ channel (valid/ready). A sample tick yields one result
// on the out_ channel: the Q1.15 sample and the step it was made in. A step tick
// advances the step index, wrapping after STEPS - 1; a write item loads the
// carrier multiple and modulator height of one step. Other codes are dropped.
// Timing: an accepted item is held in the input register, where the step
// tables are read, the phases are advanced and both sines are looked up; the
// pair then goes to the sine register and the mixer multiply feeds the output
// register, which shows the result. One item is taken every cycle unless a
// sample tick waits in the input register for room in the sine register.
// Reset: phases and step index go to zero, every step to multiple one and
// height 640. No clearing pass is needed.
// Backpressure: the output register and the sine register each hold an item,
// so ticks that give no result keep flowing while a result waits; a sample
// tick waits in the input register until the sine register has room.
// ----------------------------------------------------------------------------
module step_sequenced_am_oscillator #(
  parameter int STEPS       = 16,
  parameter int SAMPLE_RATE = 44100,
  parameter int PHASE_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sao_pkg::REQ_W-1:0]           in_req_type,
  input  logic [sao_pkg::ENTRY_W-1:0]         in_entry_index,
  input  logic [sao_pkg::MULT_W-1:0]          in_carrier_multiple,
  input  logic [sao_pkg::HEIGHT_W-1:0]        in_mod_height,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sao_pkg::SAMPLE_W-1:0] out_sample,
  output logic [sao_pkg::STEP_OUT_W-1:0]      out_current_step
);

  logic               smp_valid;
  logic               smp_ready;
  sao_pkg::sao_pair_t smp;

  sao_front #(
    .STEPS       (STEPS),
    .SAMPLE_RATE (SAMPLE_RATE),
    .PHASE_BITS  (PHASE_BITS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_entry_index      (in_entry_index),
    .in_carrier_multiple (in_carrier_multiple),
    .in_mod_height       (in_mod_height),
    .smp_valid           (smp_valid),
    .smp_ready           (smp_ready),
    .smp                 (smp)
  );

  sao_mix u_mix (
    .clk              (clk),
    .rst_n            (rst_n),
    .smp_valid        (smp_valid),
    .smp_ready        (smp_ready),
    .smp              (smp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample       (out_sample),
    .out_current_step (out_current_step)
  );

endmodule
